// ----- rtl/lz77we_pkg.sv -----
// Shared constants, types and helpers for the LZ77 window match encoder.
`default_nettype none

package lz77we_pkg;

  localparam int WINDOW_SIZE = 255;
  localparam int MAX_MATCH   = 255;
  localparam int IDX_W       = 8;
  localparam int LEN_W       = 8;
  localparam int CNT_W       = 9;
  localparam int TREE_LVLS   = 8;
  localparam int TREE_LEAVES = 1 << TREE_LVLS;

  // One node of the reduction tree over the candidate row.
  typedef struct packed {
    logic [LEN_W-1:0] best_len;
    logic [IDX_W-1:0] best_idx;
    logic             thr_hit;
    logic [IDX_W-1:0] thr_idx;
    logic             any_alive;
    logic             any_fresh;
  } node_t;

  // Commands from the sequencer to every cell of the row.
  typedef struct packed {
    logic       upd;
    logic       start;
    logic       fresh;
    logic       shift;
    logic       clear;
    logic [7:0] data;
  } cell_ctl_t;

  typedef struct packed {
    logic             is_match;
    logic [LEN_W-1:0] match_length;
    logic [IDX_W-1:0] distance_code;
    logic [7:0]       tail_byte;
    logic             last_token;
  } token_t;

  // Length cap of the candidate at distance idx+1: min(MAX_MATCH, 2d).
  function automatic logic [CNT_W-1:0] cap_of(input logic [IDX_W-1:0] idx);
    logic [CNT_W-1:0] twice;
    twice = ({1'b0, idx} + CNT_W'(1)) << 1;
    return (twice > CNT_W'(MAX_MATCH)) ? CNT_W'(MAX_MATCH) : twice;
  endfunction

  // Left child holds the smaller distances, so it wins ties.
  function automatic node_t combine(input node_t a, input node_t b);
    node_t r;
    r = a;
    if (b.best_len > a.best_len) begin
      r.best_len = b.best_len;
      r.best_idx = b.best_idx;
    end
    if (!a.thr_hit) begin
      r.thr_hit = b.thr_hit;
      r.thr_idx = b.thr_idx;
    end
    r.any_alive = a.any_alive | b.any_alive;
    r.any_fresh = a.any_fresh | b.any_fresh;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lz77_window_match_encoder.sv -----
// Top level: LZ77 encoder over a 255-byte window with a row of distance cells.
`default_nettype none

// Takes one byte per request and gives LZ77 tokens (literal, or match of
// length, distance minus one and tail byte), at most two per byte. A row of
// 255 cells, one per distance, holds the history as a shift line and tracks
// every match candidate in parallel; a registered eight-level tree picks the
// longest (smallest distance on a tie). Each byte goes through an update
// state, then an evaluation state while the tree settles, and is then
// decided; its tokens are handed out one at a time, and the next byte is
// taken once all its tokens are gone. A byte flagged end of block flushes
// the pending token and clears the history.

module lz77_window_match_encoder
  import lz77we_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_end_of_block,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_is_match,
  output logic      [LEN_W-1:0] out_match_length,
  output logic      [IDX_W-1:0] out_distance_code,
  output logic      [7:0]       out_tail_byte,
  output logic                  out_last_token
);

  cell_ctl_t        ctl;
  logic [LEN_W-1:0] thr;
  node_t            root;
  node_t            leaf [TREE_LEAVES];
  logic [7:0]       hist_w   [WINDOW_SIZE];
  logic             filled_w [WINDOW_SIZE];
  token_t           out_tok;

  lz77we_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_block (in_end_of_block),
    .root            (root),
    .ctl             (ctl),
    .thr             (thr),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tok         (out_tok)
  );

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    lz77we_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .cell_idx    (IDX_W'(i)),
      .thr         (thr),
      .prev_hist   ((i == 0) ? ctl.data : hist_w[(i == 0) ? 0 : i-1]),
      .prev_filled ((i == 0) ? 1'b1 : filled_w[(i == 0) ? 0 : i-1]),
      .hist        (hist_w[i]),
      .filled      (filled_w[i]),
      .leaf        (leaf[i])
    );
  end

  for (genvar j = WINDOW_SIZE; j < TREE_LEAVES; j++) begin : g_pad
    assign leaf[j] = '0;
  end

  lz77we_tree u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  assign out_is_match      = out_tok.is_match;
  assign out_match_length  = out_tok.match_length;
  assign out_distance_code = out_tok.distance_code;
  assign out_tail_byte     = out_tok.tail_byte;
  assign out_last_token    = out_tok.last_token;

endmodule

`default_nettype wire

// ----- rtl/lz77we_cell.sv -----
// One distance cell: a history byte and the match candidate at that distance.
`default_nettype none

module lz77we_cell
  import lz77we_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic [LEN_W-1:0] thr,
  input  wire logic [7:0]       prev_hist,
  input  wire logic             prev_filled,
  output logic      [7:0]       hist,
  output logic                  filled,
  output node_t                 leaf
);

  logic [7:0]       hist_r;
  logic             filled_r;
  logic             alive_r;
  logic             fresh_r;
  logic [LEN_W-1:0] len_r;

  logic             alive_base;
  logic [LEN_W-1:0] len_base;
  logic [LEN_W-1:0] len_inc;
  logic             hit;
  logic [CNT_W-1:0] cap;

  always_comb begin
    alive_base = ctl.start ? filled_r : alive_r;
    len_base   = ctl.start ? '0 : len_r;
    len_inc    = len_base + LEN_W'(1);
    hit        = (hist_r == ctl.data);
    cap        = cap_of(cell_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
      alive_r  <= 1'b0;
      fresh_r  <= 1'b0;
      len_r    <= '0;
    end else if (ctl.clear) begin
      filled_r <= 1'b0;
      alive_r  <= 1'b0;
      fresh_r  <= 1'b0;
      len_r    <= '0;
    end else begin
      if (ctl.upd) begin
        fresh_r <= filled_r & hit;
        if (alive_base && hit) begin
          len_r   <= len_inc;
          alive_r <= ({1'b0, len_inc} < cap);
        end else begin
          len_r   <= len_base;
          alive_r <= 1'b0;
        end
      end
      // restart the token at the byte that followed a short literal
      if (ctl.fresh) begin
        alive_r <= fresh_r;
        len_r   <= {{(LEN_W-1){1'b0}}, fresh_r};
      end
      if (ctl.shift) begin
        filled_r <= prev_filled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hist_r <= prev_hist;
    end
  end

  assign hist   = hist_r;
  assign filled = filled_r;

  always_comb begin
    leaf.best_len  = len_r;
    leaf.best_idx  = cell_idx;
    leaf.thr_hit   = (len_r >= thr);
    leaf.thr_idx   = cell_idx;
    leaf.any_alive = alive_r;
    leaf.any_fresh = fresh_r;
  end

endmodule

`default_nettype wire

// ----- rtl/lz77we_tree.sv -----
// Registered binary reduction tree over the candidate row.
`default_nettype none

module lz77we_tree
  import lz77we_pkg::*;
(
  input  wire logic  clk,
  input  wire node_t leaf [TREE_LEAVES],
  output node_t      root
);

  node_t nodes_r [1:TREE_LEAVES-1];
  node_t all_n   [1:2*TREE_LEAVES-1];

  always_comb begin
    for (int i = 1; i < 2*TREE_LEAVES; i++) begin
      if (i < TREE_LEAVES) begin
        all_n[i] = nodes_r[i];
      end else begin
        all_n[i] = leaf[i-TREE_LEAVES];
      end
    end
  end

  // Every level is registered, from the leaf pairs up to the root.
  always_ff @(posedge clk) begin
    for (int i = 1; i < TREE_LEAVES; i++) begin
      nodes_r[i] <= combine(all_n[2*i], all_n[2*i+1]);
    end
  end

  assign root = nodes_r[1];

endmodule

`default_nettype wire

// ----- rtl/lz77we_ctrl.sv -----
// Sequencer: token bookkeeping, decision and result register.
`default_nettype none

module lz77we_ctrl
  import lz77we_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_end_of_block,
  input  wire node_t            root,
  output cell_ctl_t             ctl,
  output logic      [LEN_W-1:0] thr,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output token_t                out_tok
);

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_EVAL, S_EMIT} state_t;

  localparam logic [3:0] EVAL_DONE = 4'(TREE_LVLS);

  state_t           state_r;
  logic [3:0]       cnt_r;
  logic [CNT_W-1:0] n_r;
  logic [7:0]       first_r;
  logic [7:0]       byte_r;
  logic             eob_r;
  logic             start_r;
  logic [LEN_W-1:0] thr_r;
  token_t           tok_r [2];
  logic [1:0]       ntok_r;
  logic             tidx_r;

  logic             decide;
  logic             hold;
  token_t           t0_nxt;
  token_t           t1_nxt;
  logic [1:0]       ntok_nxt;
  logic [CNT_W-1:0] n_nxt;
  logic [7:0]       first_nxt;
  logic             fresh_nxt;

  function automatic token_t lit(input logic [7:0] b, input logic last);
    token_t t;
    t.is_match      = 1'b0;
    t.match_length  = '0;
    t.distance_code = '0;
    t.tail_byte     = b;
    t.last_token    = last;
    return t;
  endfunction

  function automatic token_t mat(input logic [LEN_W-1:0] len,
                                 input logic [IDX_W-1:0] dc,
                                 input logic [7:0] b, input logic last);
    token_t t;
    t.is_match      = 1'b1;
    t.match_length  = len;
    t.distance_code = dc;
    t.tail_byte     = b;
    t.last_token    = last;
    return t;
  endfunction

  assign decide = (state_r == S_EVAL) && (cnt_r == EVAL_DONE);

  always_comb begin
    hold      = root.any_alive || ({1'b0, root.best_len} >= n_r);
    t0_nxt    = lit(byte_r, eob_r);
    t1_nxt    = lit(byte_r, eob_r);
    ntok_nxt  = 2'd0;
    n_nxt     = '0;
    first_nxt = first_r;
    fresh_nxt = 1'b0;
    if (hold) begin
      n_nxt = n_r;
      if (eob_r) begin
        if (n_r >= CNT_W'(3)) begin
          t0_nxt   = mat(LEN_W'(n_r - CNT_W'(1)), root.thr_idx, byte_r, 1'b1);
          ntok_nxt = 2'd1;
        end else if (n_r == CNT_W'(2)) begin
          t0_nxt   = lit(first_r, 1'b0);
          t1_nxt   = lit(byte_r, 1'b1);
          ntok_nxt = 2'd2;
        end else begin
          t0_nxt   = lit(byte_r, 1'b1);
          ntok_nxt = 2'd1;
        end
      end
    end else if (root.best_len >= LEN_W'(2)) begin
      t0_nxt   = mat(root.best_len, root.best_idx, byte_r, eob_r);
      ntok_nxt = 2'd1;
    end else if (n_r == CNT_W'(1)) begin
      t0_nxt   = lit(byte_r, eob_r);
      ntok_nxt = 2'd1;
    end else begin
      // literal of the first byte; the second byte opens a new token or is a literal
      t0_nxt = lit(first_r, 1'b0);
      if (root.any_fresh && !eob_r) begin
        ntok_nxt  = 2'd1;
        n_nxt     = CNT_W'(1);
        first_nxt = byte_r;
        fresh_nxt = 1'b1;
      end else begin
        t1_nxt   = lit(byte_r, eob_r);
        ntok_nxt = 2'd2;
      end
    end
    if (eob_r) begin
      n_nxt     = '0;
      first_nxt = '0;
    end
  end

  always_comb begin
    ctl.upd   = (state_r == S_UPD);
    ctl.start = start_r;
    ctl.data  = byte_r;
    ctl.fresh = decide & fresh_nxt;
    ctl.shift = decide & ~eob_r;
    ctl.clear = decide & eob_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
      first_r <= '0;
      start_r <= 1'b0;
      ntok_r  <= '0;
      tidx_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            byte_r  <= in_data_byte;
            eob_r   <= in_end_of_block;
            start_r <= (n_r == '0);
            thr_r   <= n_r[LEN_W-1:0];
            n_r     <= n_r + CNT_W'(1);
            if (n_r == '0) begin
              first_r <= in_data_byte;
            end
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          cnt_r   <= '0;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (decide) begin
            tok_r[0] <= t0_nxt;
            tok_r[1] <= t1_nxt;
            ntok_r   <= ntok_nxt;
            tidx_r   <= 1'b0;
            n_r      <= n_nxt;
            first_r  <= first_nxt;
            state_r  <= (ntok_nxt == 2'd0) ? S_IDLE : S_EMIT;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if ({1'b0, tidx_r} + 2'd1 == ntok_r) begin
              state_r <= S_IDLE;
            end else begin
              tidx_r <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_tok   = tok_r[tidx_r];
  assign thr       = thr_r;

endmodule

`default_nettype wire

// ----- tb/sv/lz77_window_match_encoder_checker.sv -----
// Token predictor and scoreboard for the LZ77 window match encoder.
module lz77_window_match_encoder_checker
  import lz77we_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_block,
  input  logic       out_valid,
  input  logic       out_ready,
  input  token_t     out_token,
  output int         fail_count,
  output int         tokens_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  hist [WINDOW_SIZE];
  int unsigned wr_pos;
  int unsigned hist_fill;
  bit          cand_live [WINDOW_SIZE];
  int unsigned cand_len [WINDOW_SIZE];
  int unsigned tok_bytes;
  logic [7:0]  tok_first;
  token_t      token_queue[$];

  assign tokens_pending = token_queue.size();

  function automatic void push_token(bit m, int unsigned len, int unsigned dc,
                                     logic [7:0] tail);
    token_t t;
    t.is_match      = m;
    t.match_length  = LEN_W'(len);
    t.distance_code = IDX_W'(dc);
    t.tail_byte     = tail;
    t.last_token    = 1'b0;
    token_queue = {token_queue, t};
  endfunction

  // Extend every candidate with byte b and decide the token when it is settled.
  function automatic void match_byte(logic [7:0] b);
    int unsigned cap, best_len, best_d;
    bit live_any;
    best_len = 0;
    best_d   = 1;
    live_any = 0;
    if (tok_bytes == 0) begin
      tok_first = b;
      for (int d = 1; d <= WINDOW_SIZE; d++) begin
        cand_live[d-1] = (d <= hist_fill);
        cand_len[d-1]  = 0;
      end
    end
    for (int d = 1; d <= WINDOW_SIZE; d++) begin
      if (cand_live[d-1]) begin
        cap = (2*d > MAX_MATCH) ? MAX_MATCH : 2*d;
        if (hist[(wr_pos + WINDOW_SIZE - d) % WINDOW_SIZE] == b) begin
          cand_len[d-1]++;
          if (cand_len[d-1] >= cap) cand_live[d-1] = 0;
        end else begin
          cand_live[d-1] = 0;
        end
      end
      if (cand_live[d-1]) live_any = 1;
      if (cand_len[d-1] > best_len) begin
        best_len = cand_len[d-1];
        best_d   = d;
      end
    end
    tok_bytes++;
    if (live_any || best_len >= tok_bytes) return;
    if (best_len >= 2) begin
      push_token(1, best_len, best_d - 1, b);
      tok_bytes = 0;
      return;
    end
    if (tok_bytes == 1) begin
      tok_bytes = 0;
      push_token(0, 0, 0, b);
      return;
    end
    tok_bytes = 0;
    push_token(0, 0, 0, tok_first);
    match_byte(b);
  endfunction

  function automatic void clear_block();
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      cand_live[i] = 0;
      cand_len[i]  = 0;
    end
    wr_pos    = 0;
    hist_fill = 0;
    tok_bytes = 0;
    tok_first = '0;
  endfunction

  function automatic void predict(logic [7:0] b, bit eob);
    int unsigned base, pick;
    base = token_queue.size();
    match_byte(b);
    if (!eob) begin
      hist[wr_pos] = b;
      wr_pos = (wr_pos + 1) % WINDOW_SIZE;
      if (hist_fill < WINDOW_SIZE) hist_fill++;
      return;
    end
    // flush the pending token
    if (tok_bytes >= 3) begin
      pick = 1;
      for (int d = WINDOW_SIZE; d >= 1; d--)
        if (cand_len[d-1] >= tok_bytes - 1) pick = d;
      push_token(1, tok_bytes - 1, pick - 1, b);
    end else if (tok_bytes == 2) begin
      push_token(0, 0, 0, tok_first);
      push_token(0, 0, 0, b);
    end else if (tok_bytes == 1) begin
      push_token(0, 0, 0, b);
    end
    if (token_queue.size() > base)
      token_queue[token_queue.size()-1].last_token = 1'b1;
    clear_block();
  endfunction

  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      clear_block();
      token_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) predict(in_data_byte, in_end_of_block);
      if (out_valid && out_ready) begin
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token, actual %p", $realtime, out_token);
          fail_count <= fail_count + 1;
        end else begin
          want = token_queue.pop_front();
          if (want !== out_token) begin
            $display("%0t: token mismatch, expected %p, actual %p",
                     $realtime, want, out_token);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/lz77_window_match_encoder_test.sv -----
// Stimulus and verdict for the LZ77 window match encoder.
module lz77_window_match_encoder_test;
  import lz77we_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_ready;
  logic [7:0] in_data_byte = '0;
  logic       in_end_of_block = 0;
  logic       out_valid;
  logic       out_ready = 0;
  token_t     out_token;
  int         fail_count;
  int         tokens_pending;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         quiet_cycles = 0;
  logic [7:0] pattern [16];
  int         pattern_len;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  lz77_window_match_encoder i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_end_of_block,
    .out_valid, .out_ready,
    .out_is_match(out_token.is_match),
    .out_match_length(out_token.match_length),
    .out_distance_code(out_token.distance_code),
    .out_tail_byte(out_token.tail_byte),
    .out_last_token(out_token.last_token)
  );

  lz77_window_match_encoder_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_end_of_block,
    .out_valid, .out_ready, .out_token, .fail_count, .tokens_pending
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold valid across requests; drop it only while idling.
  task automatic send_byte(logic [7:0] b, bit eob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid        <= 1;
    in_data_byte    <= b;
    in_end_of_block <= eob;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Repeating pattern with occasional corruption, so long matches form.
  task automatic send_block(int n);
    pattern_len = $urandom_range(1, 16);
    for (int i = 0; i < pattern_len; i++) pattern[i] = 8'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_byte(8'($urandom), i == n - 1);
      else
        send_byte(pattern[i % pattern_len], i == n - 1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: lone bytes, two-byte flush, extremes, overlap and cap
    send_byte(8'h00, 1);
    send_byte(8'hFF, 0); send_byte(8'h00, 1);
    send_byte(8'hAA, 0); send_byte(8'hAA, 0); send_byte(8'hAA, 0);
    send_byte(8'hAA, 0); send_byte(8'h55, 0);
    send_byte(8'h01, 0); send_byte(8'h02, 0); send_byte(8'h01, 0);
    send_byte(8'h02, 0); send_byte(8'h01, 0); send_byte(8'h02, 0);
    send_byte(8'h7F, 0); send_byte(8'h80, 1);
    send_byte(8'h11, 0); send_byte(8'h11, 0); send_byte(8'h11, 0);
    send_byte(8'h11, 1);
    // hold until the pipe drains
    in_valid <= 0;
    while (tokens_pending != 0) @(negedge clk);
    // long run of one byte: lengths capped at twice the distance
    for (int i = 0; i < 256; i++) send_byte(8'h33, i == 255);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 28 : 0;
      for (int k = 0; k < 50;) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        send_block(n);
        k += n;
      end
    end

    in_valid <= 0;
    while (tokens_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && tokens_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- lz77_window_match_encoder.f -----
rtl/lz77we_pkg.sv
rtl/lz77we_cell.sv
rtl/lz77we_tree.sv
rtl/lz77we_ctrl.sv
rtl/lz77_window_match_encoder.sv
tb/sv/lz77_window_match_encoder_checker.sv
tb/sv/lz77_window_match_encoder_test.sv
